/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the chain marginals block.
// Included by the modules that carry concurrent assertions; depends on clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/ccpm_pkg.sv */
// Shared types, constants and log-domain arithmetic for the chain marginals block.
// No dependencies; used by ccpm_cell and the top level.
package ccpm_pkg;

  localparam int MaxVars   = 64;
  localparam int MaxCount  = 15;
  localparam int ValueBits = 16;

  // Wide signed working type, holds any value sum of the 32-bit-max format
  localparam int WideW = 34;
  typedef logic signed [WideW-1:0] wide_t;

  localparam wide_t I32Max = 34'sd2147483647;
  localparam wide_t I32Min = -34'sd2147483648;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_BWD,
    CELL_FWD,
    CELL_NORM,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    wide_t    p;
    wide_t    s;
  } cell_ctl_t;

  function automatic wide_t vmax(int vb);
    return (wide_t'(1) <<< (vb - 1)) - wide_t'(1);
  endfunction

  // most negative value, stands for minus infinity
  function automatic wide_t vneg(int vb);
    return -vmax(vb) - wide_t'(1);
  endfunction

  function automatic wide_t sat(wide_t x, int vb);
    wide_t hi;
    wide_t lo;
    hi = vmax(vb);
    lo = vneg(vb);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic wide_t addv(wide_t a, wide_t b, int vb);
    if (a == vneg(vb) || b == vneg(vb)) return vneg(vb);
    return sat(a + b, vb);
  endfunction

  function automatic wide_t subv(wide_t a, wide_t s, int vb);
    if (a == vneg(vb)) return vneg(vb);
    return sat(a - s, vb);
  endfunction

  // round(1024*ln(1+exp(-i/4)))
  function automatic logic [9:0] sp_tab(logic [4:0] i);
    logic [9:0] r;
    unique case (i)
      5'd0: r = 10'd710;   5'd1: r = 10'd590;   5'd2: r = 10'd485;   5'd3: r = 10'd396;
      5'd4: r = 10'd321;   5'd5: r = 10'd258;   5'd6: r = 10'd206;   5'd7: r = 10'd164;
      5'd8: r = 10'd130;   5'd9: r = 10'd103;   5'd10: r = 10'd81;   5'd11: r = 10'd63;
      5'd12: r = 10'd50;   5'd13: r = 10'd39;   5'd14: r = 10'd30;   5'd15: r = 10'd24;
      5'd16: r = 10'd19;   5'd17: r = 10'd15;   5'd18: r = 10'd11;   5'd19: r = 10'd9;
      5'd20: r = 10'd7;    5'd21: r = 10'd5;    5'd22: r = 10'd4;    5'd23: r = 10'd3;
      5'd24: r = 10'd3;    5'd25: r = 10'd2;    5'd26: r = 10'd2;    5'd27: r = 10'd1;
      5'd28: r = 10'd1;    5'd29: r = 10'd1;    5'd30: r = 10'd1;    default: r = 10'd0;
    endcase
    return r;
  endfunction

  // round(65536*2^(-i/16)), i = 0..16
  function automatic logic [16:0] pow_tab(logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0: r = 17'd65536;  5'd1: r = 17'd62757;  5'd2: r = 17'd60097;  5'd3: r = 17'd57549;
      5'd4: r = 17'd55109;  5'd5: r = 17'd52773;  5'd6: r = 17'd50535;  5'd7: r = 17'd48393;
      5'd8: r = 17'd46341;  5'd9: r = 17'd44376;  5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
      5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734; 5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // log-add: max plus correction from table, differences of 8.0 and up add nothing
  function automatic wide_t ladd(wide_t a, wide_t b, int vb);
    wide_t hi;
    wide_t lo;
    wide_t d;
    wide_t t;
    if (a == vneg(vb)) return b;
    if (b == vneg(vb)) return a;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    d  = hi - lo;
    t  = (d >= wide_t'(8192)) ? wide_t'(0) : wide_t'(sp_tab(d[12:8]));
    return sat(hi + t, vb);
  endfunction

  // accumulate into the 32-bit log partition; minus infinity sticks
  function automatic logic signed [31:0] lz_add(logic signed [31:0] acc, wide_t s, int vb);
    wide_t v;
    if (s == vneg(vb)) return I32Min[31:0];
    if (wide_t'(acc) == I32Min) return acc;
    v = wide_t'(acc) + s;
    if (v > I32Max) v = I32Max;
    if (v < I32Min) v = I32Min;
    return v[31:0];
  endfunction

endpackage

/* rtl/core/ccpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccpm_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ccpm_cell.sv */
// One count-state cell of the message row: holds one value, trades with neighbors.
// Depends on ccpm_pkg for the cell operations and log-domain arithmetic.
module ccpm_cell import ccpm_pkg::*; #(
  parameter int VB = ValueBits
) (
  input  logic                 clk_i,
  input  cell_ctl_t            ctl_i,
  input  logic                 first_i,
  input  logic                 last_i,
  input  logic signed [VB-1:0] load_i,
  input  logic signed [VB-1:0] left_i,
  input  logic signed [VB-1:0] right_i,
  output logic signed [VB-1:0] val_o
);

  logic signed [VB-1:0] val_q, val_d;
  wide_t nb;
  wide_t res;

  // one message update per cycle when ctl_i selects one, neighbor value comes in from left or right
  always_comb begin
    nb  = '0;
    res = wide_t'(val_q);
    unique case (ctl_i.op)
      CELL_HOLD: res = wide_t'(val_q);
      CELL_LOAD: res = wide_t'(load_i);
      CELL_BWD: begin
        nb  = addv(ctl_i.p, first_i ? vneg(VB) : wide_t'(left_i), VB);
        res = ladd(wide_t'(val_q), nb, VB);
      end
      CELL_FWD: begin
        nb  = addv(ctl_i.p, last_i ? vneg(VB) : wide_t'(right_i), VB);
        res = ladd(wide_t'(val_q), nb, VB);
      end
      CELL_NORM: res = subv(wide_t'(val_q), ctl_i.s, VB);
      CELL_ROT:  res = wide_t'(right_i);
      default:   res = wide_t'(val_q);
    endcase
    val_d = res[VB-1:0];
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* rtl/core/chain_count_potential_marginals_unit.sv */
// One instance at a time; each variable costs four sweeps over the cell chain (backward row
// write, backward row sum, forward marginal, forward row sum) plus setup states.
// Potentials are taken one per cycle while loading; the final result may wait in the output
// register while the next instance loads. Reset clears control and config (count_min 0,
// count_max 15); the potential and message memories are left unset.
`include "assert_macros.svh"

module chain_count_potential_marginals_unit import ccpm_pkg::*; #(
  parameter int MAX_VARS   = MaxVars,
  parameter int MAX_COUNT  = MaxCount,
  parameter int VALUE_BITS = ValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] node_potential
  input  logic        s_axis_tlast,  // last_potential
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [15:0] marginal, [47:16] log_partition
  output logic        m_axis_tlast,  // last_result
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int VB     = VALUE_BITS;
  localparam int Stride = MAX_COUNT + 1;
  localparam int KW     = $clog2(Stride);
  localparam int JW     = $clog2(Stride + 1);
  localparam int AW     = $clog2(MAX_VARS);
  localparam int CW     = $clog2(MAX_VARS + 1);
  localparam int BDepth = MAX_VARS * (2 ** KW);
  localparam int ZW     = VB + 2;
  localparam int PW     = VB + 12;
  localparam logic signed [VB-1:0] VNeg = {1'b1, {(VB-1){1'b0}}};

  localparam logic REG_COUNT_MIN = 1'b0;
  localparam logic REG_COUNT_MAX = 1'b1;

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_BINIT = 5'd1;
  localparam logic [4:0] S_BWR   = 5'd2;
  localparam logic [4:0] S_BP    = 5'd3;
  localparam logic [4:0] S_BSTEP = 5'd4;
  localparam logic [4:0] S_BLSE  = 5'd5;
  localparam logic [4:0] S_BNORM = 5'd6;
  localparam logic [4:0] S_FINIT = 5'd7;
  localparam logic [4:0] S_FP    = 5'd8;
  localparam logic [4:0] S_FRD   = 5'd9;
  localparam logic [4:0] S_FACC  = 5'd10;
  localparam logic [4:0] S_FB1   = 5'd11;
  localparam logic [4:0] S_MG0   = 5'd12;
  localparam logic [4:0] S_MG1   = 5'd13;
  localparam logic [4:0] S_MG2   = 5'd14;
  localparam logic [4:0] S_MOUT  = 5'd15;
  localparam logic [4:0] S_FSTEP = 5'd16;
  localparam logic [4:0] S_FLSE  = 5'd17;
  localparam logic [4:0] S_FNORM = 5'd18;
  localparam logic [4:0] S_FEND  = 5'd19;
  localparam logic [4:0] S_LPRD  = 5'd20;
  localparam logic [4:0] S_LPACC = 5'd21;
  localparam logic [4:0] S_LPEND = 5'd22;

  function automatic wide_t ex(logic signed [VB-1:0] x);
    return wide_t'(x);
  endfunction

  // registers
  logic [4:0]           state_q, state_d;
  logic [3:0]           cmin_q, cmax_q;
  logic [CW-1:0]        var_cnt_q, var_cnt_d;
  logic [CW-1:0]        nvar_q, nvar_d;
  logic [JW-1:0]        kc_q, kc_d;
  logic [AW-1:0]        d_q, d_d;
  logic [JW-1:0]        j_q, j_d;
  logic signed [VB-1:0] acc_q, acc_d;
  logic signed [VB-1:0] b0_q, b0_d, b1_q, b1_d;
  logic signed [VB-1:0] p_q, p_d;
  logic signed [VB-1:0] bl1_q, bl1_d;
  logic signed [31:0]   lp_q, lp_d;
  logic                 last_flag_q, last_flag_d;
  logic [VB:0]          t_q, t_d;
  logic                 zero_q, zero_d;
  logic [ZW-1:0]        z_q, z_d;
  logic [15:0]          marg_q, marg_d;
  logic                 out_valid_q;
  logic [15:0]          out_marg_q;
  logic signed [31:0]   out_lp_q;
  logic                 out_last_q;

  // memories
  logic                    pot_we;
  logic [AW-1:0]           pot_waddr, pot_raddr;
  logic [15:0]             pot_rdata;
  logic                    bs_we;
  logic [AW+KW-1:0]        bs_waddr, bs_raddr;
  logic signed [VB-1:0]    bs_rdata;

  // cell chain
  cell_ctl_t            cell_ctl;
  logic signed [VB-1:0] cell_val [Stride];

  logic       in_acc;
  logic       out_free;
  logic [CW-1:0] nv;
  logic [JW-1:0] j_inc;
  int         km;
  wide_t      w0, w1, ws, wt;
  logic [PW-1:0] prod;
  logic [ZW-11:0] zn;
  logic [16:0] ph, ph1, pv;
  logic [23:0] ip;
  logic [16:0] mv;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD);
  assign j_inc    = JW'(j_q + 1'b1);
  assign nv       = (var_cnt_q < CW'(MAX_VARS)) ? CW'(var_cnt_q + 1'b1) : CW'(MAX_VARS);

  // potential store writes while loading
  assign pot_we    = in_acc && ((var_cnt_q < CW'(MAX_VARS)) || s_axis_tlast);
  assign pot_waddr = (var_cnt_q < CW'(MAX_VARS)) ? var_cnt_q[AW-1:0] : AW'(MAX_VARS - 1);
  assign pot_raddr = (state_q == S_BP) ? AW'(d_q - 1'b1) : d_q;

  // backward store: rows written from cell 0 during rotation
  assign bs_we    = (state_q == S_BWR);
  assign bs_waddr = {d_q, j_q[KW-1:0]};
  always_comb begin
    unique case (state_q)
      S_FRD:   bs_raddr = {AW'(d_q + 1'b1), {KW{1'b0}}};
      S_FACC:  bs_raddr = {AW'(d_q + 1'b1), j_inc[KW-1:0]};
      S_LPACC: bs_raddr = {{AW{1'b0}}, j_inc[KW-1:0]};
      default: bs_raddr = {AW+KW{1'b0}};
    endcase
  end

  ccpm_ram #(.W(16), .DEPTH(MAX_VARS)) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (pot_we),
    .waddr_i (pot_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (pot_raddr),
    .rdata_o (pot_rdata)
  );

  ccpm_ram #(.W(VB), .DEPTH(BDepth)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bs_we),
    .waddr_i (bs_waddr),
    .wdata_i (cell_val[0]),
    .raddr_i (bs_raddr),
    .rdata_o (bs_rdata)
  );

  // row of count-state cells; rotation moves each value one place toward cell 0
  for (genvar k = 0; k < Stride; k++) begin : g_cell
    localparam int Lk = (k == 0) ? 0 : k - 1;
    localparam int Rk = (k + 1) % Stride;
    logic signed [VB-1:0] ld;
    always_comb begin
      if (state_q == S_FINIT) begin
        ld = (k >= int'(cmin_q)) ? '0 : VNeg;
      end else if (k == 0) begin
        ld = '0;
      end else if (k == 1) begin
        ld = bl1_q;
      end else begin
        ld = VNeg;
      end
    end
    ccpm_cell #(.VB(VB)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .first_i (k == 0),
      .last_i  (kc_q == JW'(k + 1)),
      .load_i  (ld),
      .left_i  (cell_val[Lk]),
      .right_i (cell_val[Rk]),
      .val_o   (cell_val[k])
    );
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    var_cnt_d   = var_cnt_q;
    nvar_d      = nvar_q;
    kc_d        = kc_q;
    d_d         = d_q;
    j_d         = j_q;
    acc_d       = acc_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    p_d         = p_q;
    bl1_d       = bl1_q;
    lp_d        = lp_q;
    last_flag_d = last_flag_q;
    t_d         = t_q;
    zero_d      = zero_q;
    z_d         = z_q;
    marg_d      = marg_q;
    cell_ctl.op = CELL_HOLD;
    cell_ctl.p  = ex(p_q);
    cell_ctl.s  = ex(acc_q);
    km          = int'(cmax_q);
    w0 = '0; w1 = '0; ws = '0; wt = '0;
    prod = '0; zn = '0; ph = '0; ph1 = '0; pv = '0; ip = '0; mv = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            if (km < 1) km = 1;
            if (km > MAX_COUNT) km = MAX_COUNT;
            kc_d      = JW'(km + 1);
            nvar_d    = nv;
            d_d       = AW'(nv - 1'b1);
            var_cnt_d = '0;
            lp_d      = '0;
            w0        = sat(wide_t'($signed(s_axis_tdata)), VB);
            bl1_d     = w0[VB-1:0];
            state_d   = S_BINIT;
          end else if (var_cnt_q < CW'(MAX_VARS)) begin
            var_cnt_d = CW'(var_cnt_q + 1'b1);
          end
        end
      end
      S_BINIT: begin
        cell_ctl.op = CELL_LOAD;
        j_d         = '0;
        state_d     = S_BWR;
      end
      S_BWR: begin
        cell_ctl.op = CELL_ROT;
        j_d         = j_inc;
        if (j_q == JW'(Stride - 1)) begin
          state_d = (d_q == '0) ? S_FINIT : S_BP;
        end
      end
      S_BP: state_d = S_BSTEP;
      S_BSTEP: begin
        w0          = sat(wide_t'($signed(pot_rdata)), VB);
        cell_ctl.op = CELL_BWD;
        cell_ctl.p  = w0;
        acc_d       = VNeg;
        j_d         = '0;
        state_d     = S_BLSE;
      end
      S_BLSE, S_FLSE: begin
        cell_ctl.op = CELL_ROT;
        if (j_q < kc_q) begin
          w0    = ladd(ex(acc_q), ex(cell_val[0]), VB);
          acc_d = w0[VB-1:0];
        end
        j_d = j_inc;
        if (j_q == JW'(Stride - 1)) begin
          state_d = (state_q == S_BLSE) ? S_BNORM : S_FNORM;
        end
      end
      S_BNORM: begin
        cell_ctl.op = CELL_NORM;
        lp_d        = lz_add(lp_q, ex(acc_q), VB);
        d_d         = AW'(d_q - 1'b1);
        j_d         = '0;
        state_d     = S_BWR;
      end
      S_FINIT: begin
        cell_ctl.op = CELL_LOAD;
        d_d         = '0;
        state_d     = (nvar_q == CW'(1)) ? S_FEND : S_FP;
      end
      S_FP: state_d = S_FRD;
      S_FRD: begin
        w0      = sat(wide_t'($signed(pot_rdata)), VB);
        p_d     = w0[VB-1:0];
        b0_d    = VNeg;
        b1_d    = VNeg;
        j_d     = '0;
        state_d = S_FACC;
      end
      S_FACC: begin
        cell_ctl.op = CELL_ROT;
        if (j_q < kc_q) begin
          w0   = ladd(ex(b0_q), addv(ex(bs_rdata), ex(cell_val[0]), VB), VB);
          b0_d = w0[VB-1:0];
        end
        if (j_inc < kc_q) begin
          w1   = ladd(ex(b1_q), addv(ex(bs_rdata), ex(cell_val[1]), VB), VB);
          b1_d = w1[VB-1:0];
        end
        j_d = j_inc;
        if (j_q == JW'(Stride - 1)) begin
          state_d = S_FB1;
        end
      end
      S_FB1: begin
        w1          = addv(ex(b1_q), ex(p_q), VB);
        b1_d        = w1[VB-1:0];
        last_flag_d = 1'b0;
        state_d     = S_MG0;
      end
      // marginal: exp(b1 - logadd(b0, b1)) in three register steps
      S_MG0: begin
        ws      = ladd(ex(b0_q), ex(b1_q), VB);
        zero_d  = (ws == vneg(VB)) || (b1_q == VNeg);
        wt      = ws - ex(b1_q);
        t_d     = wt[VB:0];
        state_d = S_MG1;
      end
      S_MG1: begin
        prod    = PW'(t_q) * PW'(1477) + PW'(512);
        z_d     = prod[PW-1:10];
        state_d = S_MG2;
      end
      S_MG2: begin
        zn  = z_q[ZW-1:10];
        ph  = pow_tab({1'b0, z_q[9:6]});
        ph1 = pow_tab(5'({1'b0, z_q[9:6]} + 1'b1));
        ip  = 24'(ph - ph1) * 24'(z_q[5:0]) + 24'd32;
        pv  = ph - 17'(ip[23:6]);
        mv  = (int'(zn) >= 17) ? 17'd0 : (pv >> int'(zn));
        if (zero_q) begin
          marg_d = '0;
        end else begin
          marg_d = (mv > 17'd65535) ? 16'hffff : mv[15:0];
        end
        state_d = S_MOUT;
      end
      S_MOUT: begin
        if (out_free) begin
          state_d = last_flag_q ? S_LOAD : S_FSTEP;
        end
      end
      S_FSTEP: begin
        cell_ctl.op = CELL_FWD;
        acc_d       = VNeg;
        j_d         = '0;
        state_d     = S_FLSE;
      end
      S_FNORM: begin
        cell_ctl.op = CELL_NORM;
        if (int'(d_q) + 2 < int'(nvar_q)) begin
          d_d     = AW'(d_q + 1'b1);
          state_d = S_FP;
        end else begin
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        w0      = addv(ex(cell_val[0]), '0, VB);
        w1      = addv(ex(cell_val[1]), ex(bl1_q), VB);
        b0_d    = w0[VB-1:0];
        b1_d    = w1[VB-1:0];
        acc_d   = VNeg;
        j_d     = '0;
        state_d = S_LPRD;
      end
      S_LPRD: state_d = S_LPACC;
      S_LPACC: begin
        if (j_q < kc_q) begin
          w0    = addv((int'(j_q) >= int'(cmin_q)) ? wide_t'(0) : vneg(VB), ex(bs_rdata), VB);
          w1    = ladd(ex(acc_q), w0, VB);
          acc_d = w1[VB-1:0];
        end
        j_d = j_inc;
        if (j_q == JW'(Stride - 1)) begin
          state_d = S_LPEND;
        end
      end
      S_LPEND: begin
        lp_d        = lz_add(lp_q, ex(acc_q), VB);
        last_flag_d = 1'b1;
        state_d     = S_MG0;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cmin_q      <= 4'd0;
      cmax_q      <= 4'd15;
      var_cnt_q   <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      var_cnt_q <= var_cnt_d;
      lp_q      <= lp_d;
      if (cfg_we_i && cfg_idx_i == REG_COUNT_MIN) begin
        cmin_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_COUNT_MAX) begin
        cmax_q <= cfg_data_i;
      end
      if (state_q == S_MOUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    nvar_q      <= nvar_d;
    kc_q        <= kc_d;
    d_q         <= d_d;
    j_q         <= j_d;
    acc_q       <= acc_d;
    b0_q        <= b0_d;
    b1_q        <= b1_d;
    p_q         <= p_d;
    bl1_q       <= bl1_d;
    last_flag_q <= last_flag_d;
    t_q         <= t_d;
    zero_q      <= zero_d;
    z_q         <= z_d;
    marg_q      <= marg_d;
    if (state_q == S_MOUT && out_free) begin
      out_marg_q <= marg_q;
      out_lp_q   <= last_flag_q ? lp_q : 32'sd0;
      out_last_q <= last_flag_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lp_q, out_marg_q};
  assign m_axis_tlast  = out_last_q;

  `ASSERT_CLK(a_var_cnt_bound, var_cnt_q <= CW'(MAX_VARS), "potential count past capacity")
  `ASSERT_NEXT(a_norm_to_write, state_q == S_BNORM, (state_q == S_BWR) && (j_q == '0), "backward row not written after normalize")
  `ASSERT_NEXT(a_result_loads, (state_q == S_MOUT) && out_free, m_axis_tvalid, "result not presented")

endmodule
